### src/fvm_pkg.sv
package fvm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SUPPLY_MV      = 2'd0;
    localparam t_cfg_idx CFG_POLE_PAIRS     = 2'd1;
    localparam t_cfg_idx CFG_SENSOR_REVERSE = 2'd2;
    localparam t_cfg_idx CFG_ZERO_OFFSET    = 2'd3;

    localparam int SUPPLY_W = 14;
    localparam int POLE_W   = 7;
    localparam int U2_W     = 15;
    localparam int SIN_W    = 16;
    localparam int AB_W     = 31;
    localparam int BS_W     = 48;
    localparam int SUM_W    = 50;
    localparam int R_W      = SUPPLY_W + 16;

    localparam logic [SUPPLY_W-1:0] SUPPLY_CAP = 14'd12400;
    localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 14'd12000;
    localparam logic [POLE_W-1:0]   POLE_RST   = 7'd7;

    localparam logic signed [18:0] SQRT3_Q16 = 19'sd113512;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 7;
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    // quarter-wave sine entry m of a table with 2**qbits steps per quarter, unsigned q0.15
    function automatic logic [14:0] fvm_qsin(input int unsigned m, input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned acc;
        longint unsigned s;
        x   = (64'(m) * HALF_PI_Q30) >> qbits;
        x2  = (x * x) >> 30;
        t   = x;
        acc = x;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            t = ((t * x2) >> 30) / TAYLOR_DIV[n-1];
            if (n[0]) begin
                acc = acc - t;
            end else begin
                acc = acc + t;
            end
        end
        s = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return 15'(s);
    endfunction

endpackage

### src/fvm_div.sv
module fvm_div #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 30,
    parameter int QUO_W = 16
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CMP_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    // one quotient bit per stage, msb first
    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [CMP_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [CMP_W-1:0] w_den_sh;
        logic [CMP_W:0]   w_diff;
        logic [CMP_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        if (g == 0) begin : g_first
            assign w_rem_in = CMP_W'(i_num);
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[g-1];
            assign w_den_in = r_den[g-1];
            assign w_quo_in = r_quo[g-1];
        end

        assign w_den_sh = CMP_W'(w_den_in) << (QUO_W - 1 - g);
        assign w_diff   = {1'b0, w_rem_in} - {1'b0, w_den_sh};
        assign n_rem    = w_diff[CMP_W] ? w_rem_in : w_diff[CMP_W-1:0];
        assign n_quo    = {w_quo_in[QUO_W-2:0], ~w_diff[CMP_W]};

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_den[g] <= w_den_in;
            r_quo[g] <= n_quo;
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

### src/foc_voltage_modulator.sv
// throughput: one command per cycle, busy stays low; eight arithmetic stages are followed by
// a restoring divider with one stage per duty bit, then an output register
// reset: synchronous, active low; clears the pipeline valid bits and the strobe and loads the
// supply, pole pair, direction and zero offset registers with their defaults
module foc_voltage_modulator
    import fvm_pkg::*;
#(
    parameter int ANGLE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10,
    parameter int DUTY_BITS       = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [15:0]      i_uq_mv,
    input  logic [15:0]             i_mech_angle,
    input  logic                    i_cfg_we,
    input  t_cfg_idx                i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                    o_strobe,
    output logic [DUTY_BITS-1:0]    o_duty_a,
    output logic [DUTY_BITS-1:0]    o_duty_b,
    output logic [DUTY_BITS-1:0]    o_duty_c,
    output logic                    o_cmd_limited
);

    localparam int QUARTER  = 1 << (SINE_TABLE_BITS - 2);
    localparam int QIDX_W   = SINE_TABLE_BITS - 1;
    localparam int NUM_W    = R_W + DUTY_BITS;
    localparam int PIPE_LEN = 8 + DUTY_BITS;
    localparam int LATENCY  = PIPE_LEN + 1;
    localparam logic [QIDX_W-1:0] QUARTER_IDX = QIDX_W'(QUARTER);

    // configuration registers
    logic [SUPPLY_W-1:0] r_supply;
    logic [POLE_W-1:0]   r_pole_pairs;
    logic                r_reverse;
    logic [15:0]         r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply     <= SUPPLY_RST;
            r_pole_pairs <= POLE_RST;
            r_reverse    <= 1'b0;
            r_zero       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SUPPLY_MV:      r_supply     <= i_cfg_wdata[SUPPLY_W-1:0];
                CFG_POLE_PAIRS:     r_pole_pairs <= i_cfg_wdata[POLE_W-1:0];
                CFG_SENSOR_REVERSE: r_reverse    <= i_cfg_wdata[0];
                CFG_ZERO_OFFSET:    r_zero       <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [SUPPLY_W-1:0] w_sup;
    assign w_sup = (r_supply > SUPPLY_CAP) ? SUPPLY_CAP : r_supply;

    assign busy = 1'b0;

    // valid and clamp flag travel with the data
    logic [PIPE_LEN-1:0] r_vld_pipe;
    logic [PIPE_LEN-1:0] r_lim_pipe;
    logic                n_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pipe <= '0;
        end else begin
            r_vld_pipe <= {r_vld_pipe[PIPE_LEN-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_pipe <= {r_lim_pipe[PIPE_LEN-2:0], n_lim};
    end

    // stage 1: command clamp, pole pair product
    logic signed [16:0]       w_u2;
    logic signed [16:0]       w_sup_s;
    logic signed [U2_W-1:0]   n_s1_u2;
    logic [ANGLE_BITS-1:0]    w_mech_ang;
    logic [ANGLE_BITS-1:0]    w_zero_ang;
    logic [ANGLE_BITS+POLE_W-1:0] w_prod_full;
    logic signed [U2_W-1:0]   r_s1_u2;
    logic [ANGLE_BITS-1:0]    r_s1_prod;

    if (ANGLE_BITS >= 16) begin : g_ang_wide
        assign w_mech_ang = ANGLE_BITS'(i_mech_angle) << (ANGLE_BITS - 16);
        assign w_zero_ang = ANGLE_BITS'(r_zero) << (ANGLE_BITS - 16);
    end else begin : g_ang_narrow
        assign w_mech_ang = ANGLE_BITS'(i_mech_angle >> (16 - ANGLE_BITS));
        assign w_zero_ang = ANGLE_BITS'(r_zero >> (16 - ANGLE_BITS));
    end

    assign w_u2        = {i_uq_mv, 1'b0};
    assign w_sup_s     = $signed({3'b000, w_sup});
    assign w_prod_full = r_pole_pairs * w_mech_ang;

    always_comb begin
        n_lim   = 1'b0;
        n_s1_u2 = U2_W'(w_u2);
        if (w_u2 > w_sup_s) begin
            n_s1_u2 = U2_W'(w_sup_s);
            n_lim   = 1'b1;
        end else if (w_u2 < -w_sup_s) begin
            n_s1_u2 = U2_W'(-w_sup_s);
            n_lim   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_u2   <= n_s1_u2;
        r_s1_prod <= w_prod_full[ANGLE_BITS-1:0];
    end

    // stage 2: direction, zero offset, table index
    logic [ANGLE_BITS-1:0]      w_dir;
    logic [ANGLE_BITS-1:0]      w_elec;
    logic [SINE_TABLE_BITS-1:0] n_s2_k;
    logic [SINE_TABLE_BITS-1:0] r_s2_k;
    logic signed [U2_W-1:0]     r_s2_u2;

    assign w_dir  = r_reverse ? (ANGLE_BITS'(0) - r_s1_prod) : r_s1_prod;
    assign w_elec = w_dir - w_zero_ang;

    if (ANGLE_BITS >= SINE_TABLE_BITS) begin : g_k_trunc
        assign n_s2_k = w_elec[ANGLE_BITS-1 -: SINE_TABLE_BITS];
    end else begin : g_k_shift
        assign n_s2_k = SINE_TABLE_BITS'(w_elec) << (SINE_TABLE_BITS - ANGLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_s2_k  <= n_s2_k;
        r_s2_u2 <= r_s1_u2;
    end

    // stage 3: quarter-wave lookup for sin and cos
    logic [14:0] w_qtab [0:QUARTER];

    for (genvar gm = 0; gm <= QUARTER; gm++) begin : g_qtab
        localparam logic [14:0] QS_VAL = fvm_qsin(gm, SINE_TABLE_BITS - 2);
        assign w_qtab[gm] = QS_VAL;
    end

    logic [1:0]               w_quad;
    logic [QIDX_W-1:0]        w_idx_fwd;
    logic [QIDX_W-1:0]        w_idx_rev;
    logic signed [SIN_W-1:0]  w_tab_fwd;
    logic signed [SIN_W-1:0]  w_tab_rev;
    logic signed [SIN_W-1:0]  n_s3_sn;
    logic signed [SIN_W-1:0]  n_s3_cs;
    logic signed [SIN_W-1:0]  r_s3_sn;
    logic signed [SIN_W-1:0]  r_s3_cs;
    logic signed [U2_W-1:0]   r_s3_u2;

    assign w_quad    = r_s2_k[SINE_TABLE_BITS-1 -: 2];
    assign w_idx_fwd = {1'b0, r_s2_k[SINE_TABLE_BITS-3:0]};
    assign w_idx_rev = QUARTER_IDX - w_idx_fwd;
    assign w_tab_fwd = $signed({1'b0, w_qtab[w_idx_fwd]});
    assign w_tab_rev = $signed({1'b0, w_qtab[w_idx_rev]});

    always_comb begin
        case (w_quad)
            2'd0: begin
                n_s3_sn = w_tab_fwd;
                n_s3_cs = w_tab_rev;
            end
            2'd1: begin
                n_s3_sn = w_tab_rev;
                n_s3_cs = -w_tab_fwd;
            end
            2'd2: begin
                n_s3_sn = -w_tab_fwd;
                n_s3_cs = -w_tab_rev;
            end
            default: begin
                n_s3_sn = -w_tab_rev;
                n_s3_cs = w_tab_fwd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s3_sn <= n_s3_sn;
        r_s3_cs <= n_s3_cs;
        r_s3_u2 <= r_s2_u2;
    end

    // stage 4: inverse park with ud of zero
    logic signed [AB_W-1:0] w_u_sn;
    logic signed [AB_W-1:0] n_s4_beta;
    logic signed [AB_W-1:0] r_s4_alpha;
    logic signed [AB_W-1:0] r_s4_beta;

    assign w_u_sn    = r_s3_u2 * r_s3_sn;
    assign n_s4_beta = r_s3_u2 * r_s3_cs;

    always_ff @(posedge i_clk) begin
        r_s4_alpha <= -w_u_sn;
        r_s4_beta  <= n_s4_beta;
    end

    // stage 5: sqrt(3) scaling of beta
    logic signed [BS_W-1:0] n_s5_bs;
    logic signed [BS_W-1:0] r_s5_bs;
    logic signed [AB_W-1:0] r_s5_alpha;

    assign n_s5_bs = r_s4_beta * SQRT3_Q16;

    always_ff @(posedge i_clk) begin
        r_s5_bs    <= n_s5_bs;
        r_s5_alpha <= r_s4_alpha;
    end

    // stage 6: inverse clarke around half the supply
    logic signed [SUM_W-1:0] w_alpha_x;
    logic signed [SUM_W-1:0] w_bs_x;
    logic signed [SUM_W-1:0] w_center;
    logic signed [SUM_W-1:0] r_s6_na;
    logic signed [SUM_W-1:0] r_s6_nb;
    logic signed [SUM_W-1:0] r_s6_nc;

    assign w_alpha_x = SUM_W'(r_s5_alpha);
    assign w_bs_x    = SUM_W'(r_s5_bs);
    assign w_center  = $signed(SUM_W'({w_sup, 32'd0}));

    always_ff @(posedge i_clk) begin
        r_s6_na <= (w_alpha_x <<< 17) + w_center;
        r_s6_nb <= w_bs_x - (w_alpha_x <<< 16) + w_center;
        r_s6_nc <= w_center - (w_alpha_x <<< 16) - w_bs_x;
    end

    // stage 7: clamp to 0..supply and scale down
    logic signed [SUM_W-1:0] w_top;
    logic [R_W-1:0]          w_r_full;
    logic [R_W-1:0]          r_s7_ra;
    logic [R_W-1:0]          r_s7_rb;
    logic [R_W-1:0]          r_s7_rc;

    assign w_top    = $signed(SUM_W'({w_sup, 33'd0}));
    assign w_r_full = {w_sup, 16'd0};

    function automatic logic [R_W-1:0] fvm_sat(input logic signed [SUM_W-1:0] v,
                                               input logic signed [SUM_W-1:0] top,
                                               input logic [R_W-1:0]          full);
        logic [R_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > top) begin
            res = full;
        end else begin
            res = v[R_W+16:17];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        r_s7_ra <= fvm_sat(r_s6_na, w_top, w_r_full);
        r_s7_rb <= fvm_sat(r_s6_nb, w_top, w_r_full);
        r_s7_rc <= fvm_sat(r_s6_nc, w_top, w_r_full);
    end

    // stage 8: rounded dividend r * (2**DUTY_BITS - 1) + den / 2
    logic [NUM_W-1:0] w_half_den;
    logic [NUM_W-1:0] r_s8_num_a;
    logic [NUM_W-1:0] r_s8_num_b;
    logic [NUM_W-1:0] r_s8_num_c;
    logic [R_W-1:0]   r_s8_den;

    assign w_half_den = NUM_W'({w_sup, 15'd0});

    always_ff @(posedge i_clk) begin
        r_s8_num_a <= (NUM_W'(r_s7_ra) << DUTY_BITS) - NUM_W'(r_s7_ra) + w_half_den;
        r_s8_num_b <= (NUM_W'(r_s7_rb) << DUTY_BITS) - NUM_W'(r_s7_rb) + w_half_den;
        r_s8_num_c <= (NUM_W'(r_s7_rc) << DUTY_BITS) - NUM_W'(r_s7_rc) + w_half_den;
        r_s8_den   <= w_r_full;
    end

    // dividers, one stage per duty bit
    logic [DUTY_BITS-1:0] w_quo_a;
    logic [DUTY_BITS-1:0] w_quo_b;
    logic [DUTY_BITS-1:0] w_quo_c;

    fvm_div #(
        .NUM_W (NUM_W),
        .DEN_W (R_W),
        .QUO_W (DUTY_BITS)
    ) u_div_a (
        .i_clk (i_clk),
        .i_num (r_s8_num_a),
        .i_den (r_s8_den),
        .o_quo (w_quo_a)
    );

    fvm_div #(
        .NUM_W (NUM_W),
        .DEN_W (R_W),
        .QUO_W (DUTY_BITS)
    ) u_div_b (
        .i_clk (i_clk),
        .i_num (r_s8_num_b),
        .i_den (r_s8_den),
        .o_quo (w_quo_b)
    );

    fvm_div #(
        .NUM_W (NUM_W),
        .DEN_W (R_W),
        .QUO_W (DUTY_BITS)
    ) u_div_c (
        .i_clk (i_clk),
        .i_num (r_s8_num_c),
        .i_den (r_s8_den),
        .o_quo (w_quo_c)
    );

    // output register, zero supply gives zero duty
    logic                 r_strobe;
    logic                 r_lim;
    logic [DUTY_BITS-1:0] r_duty_a;
    logic [DUTY_BITS-1:0] r_duty_b;
    logic [DUTY_BITS-1:0] r_duty_c;
    logic                 w_sup_zero;

    assign w_sup_zero = (w_sup == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld_pipe[PIPE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= r_lim_pipe[PIPE_LEN-1];
        r_duty_a <= w_sup_zero ? '0 : w_quo_a;
        r_duty_b <= w_sup_zero ? '0 : w_quo_b;
        r_duty_c <= w_sup_zero ? '0 : w_quo_c;
    end

    assign o_strobe      = r_strobe;
    assign o_cmd_limited = r_lim;
    assign o_duty_a      = r_duty_a;
    assign o_duty_b      = r_duty_b;
    assign o_duty_c      = r_duty_c;

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(LATENCY) o_strobe)
        else $error("accepted command produced no result at the expected cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result strobe without a matching command");
`endif

endmodule
